@@ src/tltz_pkg.sv @@
// shared types, constants and the arctangent table for the tilt level controller
// no dependencies; used by every module of the block except tltz_ram
package tltz_pkg;

  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int UV_W         = 33;
  localparam int Z_W          = 25;
  localparam int ANGLE_LIMIT  = 23040;
  localparam int REG_IDX_W    = 3;

  localparam logic [1:0] ZONE_ABOVE  = 2'd0;
  localparam logic [1:0] ZONE_BELOW  = 2'd1;
  localparam logic [1:0] ZONE_INSIDE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_TILT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_TOL     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_LOW     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_HIGH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_NEUTRAL = 3'd4;

  typedef struct packed {
    logic signed [15:0] x_accel;
    logic signed [15:0] y_accel;
  } in_t;

  typedef struct packed {
    logic        [15:0] drive_value;
    logic signed [15:0] average_angle;
    logic        [1:0]  level_zone;
  } out_t;

  typedef struct packed {
    logic signed [7:0]  target_tilt;
    logic        [6:0]  band_halfwidth;
    logic        [15:0] drive_low;
    logic        [15:0] drive_high;
    logic        [15:0] drive_neutral;
  } cfg_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      4'd0:    val = 25'sd2949120;
      4'd1:    val = 25'sd1740967;
      4'd2:    val = 25'sd919879;
      4'd3:    val = 25'sd466945;
      4'd4:    val = 25'sd234379;
      4'd5:    val = 25'sd117304;
      4'd6:    val = 25'sd58666;
      4'd7:    val = 25'sd29335;
      4'd8:    val = 25'sd14668;
      4'd9:    val = 25'sd7334;
      4'd10:   val = 25'sd3667;
      4'd11:   val = 25'sd1833;
      4'd12:   val = 25'sd917;
      4'd13:   val = 25'sd458;
      4'd14:   val = 25'sd229;
      4'd15:   val = 25'sd115;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ src/tltz_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module tltz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tltz_cordic.sv @@
// iterative vectoring cordic: tilt angle atan(x/y) in 1/256 degree
// depends on tltz_pkg
module tltz_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [15:0]                  x_accel,
  input  logic signed [15:0]                  y_accel,
  output logic                                done,
  output logic signed [tltz_pkg::ANGLE_W-1:0] angle
);

  localparam int UW = tltz_pkg::UV_W;
  localparam int ZW = tltz_pkg::Z_W;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} state_t;

  state_t                           state;
  logic signed [UW-1:0]             u;
  logic signed [UW-1:0]             v;
  logic signed [ZW-1:0]             z;
  logic [tltz_pkg::STEP_W-1:0]      step;

  logic signed [UW-1:0] x_ext, y_ext, u_init, v_init, du, dv;
  logic signed [ZW-1:0] z_round;

  assign x_ext  = {{(UW-16){x_accel[15]}}, x_accel};
  assign y_ext  = {{(UW-16){y_accel[15]}}, y_accel};
  // fold the vector into the right half plane
  assign u_init = (y_accel[15] ? -y_ext : y_ext) <<< 14;
  assign v_init = (y_accel[15] ? -x_ext : x_ext) <<< 14;
  // shared shifter: floor shifts by the iteration count
  assign du      = v >>> step;
  assign dv      = u >>> step;
  assign z_round = (z + ZW'(128)) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            if (y_accel == 16'sd0) begin
              if (x_accel == 16'sd0) begin
                angle <= '0;
              end else if (x_accel[15]) begin
                angle <= tltz_pkg::ANGLE_W'(-tltz_pkg::ANGLE_LIMIT);
              end else begin
                angle <= tltz_pkg::ANGLE_W'(tltz_pkg::ANGLE_LIMIT);
              end
              done <= 1'b1;
            end else begin
              u     <= u_init;
              v     <= v_init;
              z     <= '0;
              step  <= '0;
              state <= C_RUN;
            end
          end
        end
        C_RUN: begin
          if (v > 0) begin
            u <= u + du;
            v <= v - dv;
            z <= z + tltz_pkg::atan_entry(step);
          end else begin
            u <= u - du;
            v <= v + dv;
            z <= z - tltz_pkg::atan_entry(step);
          end
          step <= step + 1'b1;
          if (step == tltz_pkg::STEP_W'(tltz_pkg::CORDIC_STEPS - 1)) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          if (z_round > ZW'(tltz_pkg::ANGLE_LIMIT)) begin
            angle <= tltz_pkg::ANGLE_W'(tltz_pkg::ANGLE_LIMIT);
          end else if (z_round < ZW'(-tltz_pkg::ANGLE_LIMIT)) begin
            angle <= tltz_pkg::ANGLE_W'(-tltz_pkg::ANGLE_LIMIT);
          end else begin
            angle <= tltz_pkg::ANGLE_W'(z_round);
          end
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

@@ src/tltz_window.sv @@
// angle history, running sum, band compare and reciprocal-multiply averaging
// depends on tltz_pkg and tltz_ram
module tltz_window #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tltz_pkg::ANGLE_W-1:0] angle,
  input  tltz_pkg::cfg_t                      cfg,
  output logic                                done,
  output tltz_pkg::out_t                      result
);

  localparam int AW          = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W       = CNT_W + 16;
  localparam int BAND_W      = SUM_W + 3;
  localparam int BAND_SCALE  = WINDOW_LEN * 256;
  localparam int AGW         = tltz_pkg::ANGLE_W;
  // |sum| stays below 2^(SUM_W-1), so a rounded-up reciprocal with this shift is exact
  localparam int RECIP_SHIFT = SUM_W - 1 + $clog2(WINDOW_LEN);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam longint RECIP   = ((longint'(1) <<< RECIP_SHIFT) + longint'(WINDOW_LEN) - 1)
                               / longint'(WINDOW_LEN);

  typedef enum logic [2:0] {W_IDLE, W_READ, W_UPDATE, W_CMP, W_MUL, W_FIN} state_t;

  state_t                        state;
  logic signed [AGW-1:0]         ang;
  logic [AW-1:0]                 wpos;
  logic [WINDOW_LEN-1:0]         valid;
  logic signed [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]              mag;
  logic [PROD_W-1:0]             prod;
  logic                          neg;

  logic [AGW-1:0]                rdata;
  logic signed [AGW-1:0]         old;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]              abs_sum;
  logic signed [9:0]             hi_deg, lo_deg;
  logic signed [BAND_W-1:0]      upper, lower, sum_wide;
  logic [AGW-1:0]                avg_mag;

  tltz_ram #(
    .WIDTH(AGW),
    .DEPTH(WINDOW_LEN)
  ) u_hist (
    .clk  (clk),
    .we   (state == W_UPDATE),
    .waddr(wpos),
    .wdata(ang),
    .raddr(wpos),
    .rdata(rdata)
  );

  // entries not yet written read as zero
  assign old      = valid[wpos] ? $signed(rdata) : '0;
  assign sum_next = sum - {{(SUM_W-AGW){old[AGW-1]}}, old}
                        + {{(SUM_W-AGW){ang[AGW-1]}}, ang};
  assign abs_sum  = sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);

  assign hi_deg   = {{2{cfg.target_tilt[7]}}, cfg.target_tilt} + {3'b000, cfg.band_halfwidth};
  assign lo_deg   = {{2{cfg.target_tilt[7]}}, cfg.target_tilt} - {3'b000, cfg.band_halfwidth};
  assign upper    = {{(BAND_W-10){hi_deg[9]}}, hi_deg} * BAND_W'(BAND_SCALE);
  assign lower    = {{(BAND_W-10){lo_deg[9]}}, lo_deg} * BAND_W'(BAND_SCALE);
  assign sum_wide = {{(BAND_W-SUM_W){sum[SUM_W-1]}}, sum};
  assign avg_mag  = prod[RECIP_SHIFT +: AGW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
      wpos  <= '0;
      valid <= '0;
      sum   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            ang   <= angle;
            state <= W_READ;
          end
        end
        W_READ: state <= W_UPDATE;
        W_UPDATE: begin
          sum         <= sum_next;
          valid[wpos] <= 1'b1;
          if (wpos == AW'(WINDOW_LEN - 1)) begin
            wpos <= '0;
          end else begin
            wpos <= wpos + 1'b1;
          end
          state <= W_CMP;
        end
        W_CMP: begin
          if (sum_wide > upper) begin
            result.drive_value <= cfg.drive_low;
            result.level_zone  <= tltz_pkg::ZONE_ABOVE;
          end else if (sum_wide < lower) begin
            result.drive_value <= cfg.drive_high;
            result.level_zone  <= tltz_pkg::ZONE_BELOW;
          end else begin
            result.drive_value <= cfg.drive_neutral;
            result.level_zone  <= tltz_pkg::ZONE_INSIDE;
          end
          mag   <= abs_sum;
          neg   <= sum[SUM_W-1];
          state <= W_MUL;
        end
        W_MUL: begin
          prod  <= PROD_W'(mag) * PROD_W'(RECIP);
          state <= W_FIN;
        end
        W_FIN: begin
          result.average_angle <= neg ? $signed(-avg_mag) : $signed(avg_mag);
          done                 <= 1'b1;
          state                <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

@@ src/tilt_level_three_zone_controller_unit.sv @@
// top level of the tilt level three zone controller: config registers, sequencing, output register
// depends on tltz_pkg, tltz_cordic and tltz_window
//
// usage
//   in channel (in_valid/in_ready/in_data) carries one leveling event: signed x and y readings.
//   out channel (out_valid/out_ready/out_data) carries one result per event: the chosen drive
//   value, the window average angle in 1/256 degree and the zone code.
//   an apb-style port writes the five registers; pready is tied high, writes take effect on the
//   access cycle. the user changes registers only while no event is in flight; the block does not enforce it.
// sequence
//   one event is in flight at a time; in_ready is low from accept until the result is loaded
//   into the output register. an event passes through 16 cordic iterations through the shared
//   add/shift datapath and a rounding step (both skipped when y is zero), one history read and
//   sum update, one band compare, one multiply by the reciprocal of the window length and one
//   output step. the next event is taken only once the previous result is in the output
//   register, so a receiver that does not keep up holds off new events.
// reset and stall
//   rst (synchronous, active high) restores register defaults and clears the history, write
//   position and running sum. while out_ready is low a finished result waits in the output
//   register; a further result then holds inside the block and in_ready stays low.
module tilt_level_three_zone_controller_unit #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tltz_pkg::in_t         in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tltz_pkg::out_t        out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {T_IDLE, T_ANGLE, T_WINDOW, T_HOLD} state_t;

  state_t                              state;
  tltz_pkg::cfg_t                      cfg;
  logic                                cordic_done;
  logic signed [tltz_pkg::ANGLE_W-1:0] angle;
  logic                                win_done;
  tltz_pkg::out_t                      win_result;
  logic                                cfg_write;
  logic [tltz_pkg::REG_IDX_W-1:0]      reg_idx;
  logic                                out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[4:2];
  assign in_ready  = (state == T_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    case (reg_idx)
      tltz_pkg::REG_TARGET_TILT:   prdata = {{24{cfg.target_tilt[7]}}, cfg.target_tilt};
      tltz_pkg::REG_ANGLE_TOL:     prdata = {25'd0, cfg.band_halfwidth};
      tltz_pkg::REG_DRIVE_LOW:     prdata = {16'd0, cfg.drive_low};
      tltz_pkg::REG_DRIVE_HIGH:    prdata = {16'd0, cfg.drive_high};
      tltz_pkg::REG_DRIVE_NEUTRAL: prdata = {16'd0, cfg.drive_neutral};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_tilt     <= 8'sd10;
      cfg.band_halfwidth  <= 7'd7;
      cfg.drive_low       <= 16'd2500;
      cfg.drive_high      <= 16'd3500;
      cfg.drive_neutral   <= 16'd3000;
    end else if (cfg_write) begin
      case (reg_idx)
        tltz_pkg::REG_TARGET_TILT:   cfg.target_tilt     <= pwdata[7:0];
        tltz_pkg::REG_ANGLE_TOL:     cfg.band_halfwidth  <= pwdata[6:0];
        tltz_pkg::REG_DRIVE_LOW:     cfg.drive_low       <= pwdata[15:0];
        tltz_pkg::REG_DRIVE_HIGH:    cfg.drive_high      <= pwdata[15:0];
        tltz_pkg::REG_DRIVE_NEUTRAL: cfg.drive_neutral   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  tltz_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (in_valid && in_ready),
    .x_accel(in_data.x_accel),
    .y_accel(in_data.y_accel),
    .done   (cordic_done),
    .angle  (angle)
  );

  tltz_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_done),
    .angle (angle),
    .cfg   (cfg),
    .done  (win_done),
    .result(win_result)
  );

  // window result registers stay put until the next start, so a held result is read from there
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (in_valid) begin
            state <= T_ANGLE;
          end
        end
        T_ANGLE: begin
          if (cordic_done) begin
            state <= T_WINDOW;
          end
        end
        T_WINDOW, T_HOLD: begin
          if (win_done || state == T_HOLD) begin
            if (out_free) begin
              out_data  <= win_result;
              out_valid <= 1'b1;
              state     <= T_IDLE;
            end else begin
              state <= T_HOLD;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

@@ src/tltz_checker.sv @@
// port-level checks for the tilt level controller, bound to the top level
// depends on tltz_pkg and tilt_level_three_zone_controller_unit
module tltz_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input tltz_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input tltz_pkg::out_t out_data
);

  // a stalled result transfer keeps valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // one event at a time: ready drops after an input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input transfer");

  a_zone_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.level_zone == tltz_pkg::ZONE_ABOVE)
               || (out_data.level_zone == tltz_pkg::ZONE_BELOW)
               || (out_data.level_zone == tltz_pkg::ZONE_INSIDE))
    else $error("undefined zone code");

  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data.average_angle) <= 16'sd23040)
               && ($signed(out_data.average_angle) >= -16'sd23040))
    else $error("average angle outside +/-90 degrees");

endmodule

bind tilt_level_three_zone_controller_unit tltz_checker u_tltz_checker (.*);

@@ test/tb_tilt_level_three_zone_controller_unit.sv @@
`timescale 1ns / 100ps
// self-checking testbench for tilt_level_three_zone_controller_unit: directed and random
// leveling events checked against set results or an in-bench cordic and window average; needs tltz_pkg and the design
module tb_tilt_level_three_zone_controller_unit;

  localparam int WINDOW_LEN   = 10;
  localparam int NUM_REGS     = 5;
  localparam int N_DIRECTED   = 24;
  localparam int NUM_PHASES   = 7;
  localparam int PHASE_ITEMS  = 107;
  localparam int TOTAL_ITEMS  = N_DIRECTED + NUM_PHASES * (WINDOW_LEN + 1 + PHASE_ITEMS);
  localparam int CALM_ITEMS   = 100;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam longint ANGLE_MAX = 23040;

  typedef struct packed {
    tltz_pkg::in_t  item;
    logic           known;
    tltz_pkg::out_t result;
  } row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  tltz_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  tltz_pkg::out_t out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [4:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  // shadow of the block: registers, angle window, running sum
  tltz_pkg::cfg_t     shadow_regs;
  logic signed [15:0] angle_window [WINDOW_LEN];
  int                 window_slot;
  longint             window_sum;

  tltz_pkg::out_t pending_results [$];
  int   fails = 0;
  int   n_results = 0;
  int   items_sent = 0;
  int   gap_pct = 0;
  int   cycles = 0;
  int   aim_x = 0;
  int   aim_y = 0;
  bit   calm = 1'b0;

  tilt_level_three_zone_controller_unit #(.WINDOW_LEN(WINDOW_LEN)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // atan(2^-i) in 1/65536 degree
  function automatic longint atan_q16(int step);
    case (step)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      default: return 115;
    endcase
  endfunction

  function automatic logic signed [15:0] tilt_from_readings(logic signed [15:0] xa,
                                                            logic signed [15:0] ya);
    longint x, y, u, v, z, du, dv, r;
    x = xa;
    y = ya;
    if (y == 0) begin
      if (x > 0) return 16'sd23040;
      if (x < 0) return -16'sd23040;
      return 16'sd0;
    end
    u = (y < 0 ? -y : y) * 16384;
    v = (y < 0 ? -x : x) * 16384;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v > 0) begin
        u += du; v -= dv; z += atan_q16(i);
      end else begin
        u -= du; v += dv; z -= atan_q16(i);
      end
    end
    // round to 1/256 degree, ties up
    r = (z + 128) >>> 8;
    if (r > ANGLE_MAX) r = ANGLE_MAX;
    if (r < -ANGLE_MAX) r = -ANGLE_MAX;
    return r[15:0];
  endfunction

  function automatic tltz_pkg::out_t advance_window(tltz_pkg::in_t rd);
    logic signed [15:0] ang;
    longint upper, lower, set_l, tol_l, avg;
    tltz_pkg::out_t res;
    ang = tilt_from_readings(rd.x_accel, rd.y_accel);
    window_sum -= angle_window[window_slot];
    angle_window[window_slot] = ang;
    window_sum += ang;
    window_slot = (window_slot + 1) % WINDOW_LEN;
    set_l = $signed(shadow_regs.target_tilt);
    tol_l = shadow_regs.band_halfwidth;
    upper = WINDOW_LEN * 256 * (set_l + tol_l);
    lower = WINDOW_LEN * 256 * (set_l - tol_l);
    // an average right on a band edge is inside
    if (window_sum > upper) begin
      res.drive_value = shadow_regs.drive_low;
      res.level_zone  = tltz_pkg::ZONE_ABOVE;
    end else if (window_sum < lower) begin
      res.drive_value = shadow_regs.drive_high;
      res.level_zone  = tltz_pkg::ZONE_BELOW;
    end else begin
      res.drive_value = shadow_regs.drive_neutral;
      res.level_zone  = tltz_pkg::ZONE_INSIDE;
    end
    avg = window_sum / WINDOW_LEN;
    res.average_angle = avg[15:0];
    return res;
  endfunction

  function automatic row_t directed_row(int idx);
    row_t r;
    r.known  = 1'b0;
    r.result = '0;
    case (idx)
      0: begin
        r.item = '{16'sd0, 16'sd0};
        r.known = 1'b1;
        r.result = '{16'd3500, 16'sd0, tltz_pkg::ZONE_BELOW};
      end
      1: begin
        r.item = '{16'sd100, 16'sd0};
        r.known = 1'b1;
        r.result = '{16'd3000, 16'sd2304, tltz_pkg::ZONE_INSIDE};
      end
      2: begin
        r.item = '{16'sh8000, 16'sd0};
        r.known = 1'b1;
        r.result = '{16'd3500, 16'sd0, tltz_pkg::ZONE_BELOW};
      end
      3:  r.item = '{16'sd0, 16'sd500};
      4:  r.item = '{16'sd0, -16'sd500};
      5:  r.item = '{16'sd0, 16'sh8000};
      6:  r.item = '{16'sh7fff, 16'sh7fff};
      7:  r.item = '{16'sh8000, 16'sh8000};
      8:  r.item = '{16'sh7fff, 16'sh8000};
      9:  r.item = '{16'sh8000, 16'sh7fff};
      10: r.item = '{16'sd1, 16'sh7fff};
      11: r.item = '{-16'sd1, 16'sh8000};
      12: r.item = '{16'sh7fff, 16'sd1};
      13: r.item = '{16'sh8000, -16'sd1};
      14: r.item = '{16'sd1, 16'sd1};
      15: r.item = '{-16'sd1, 16'sd1};
      16: r.item = '{16'sd1, -16'sd1};
      17: r.item = '{-16'sd1, -16'sd1};
      18: r.item = '{16'sh5555, 16'shaaaa};
      19: r.item = '{16'shaaaa, 16'sh5555};
      20: r.item = '{16'sh7fff, 16'sd0};
      21: r.item = '{-16'sd1, 16'sd0};
      22: r.item = '{16'sd12345, -16'sd6789};
      default: r.item = '{16'sd7000, 16'sd30000};
    endcase
    return r;
  endfunction

  function automatic tltz_pkg::cfg_t phase_setting(int p);
    tltz_pkg::cfg_t c;
    case (p)
      0: c = '{-8'sd90, 7'd0, 16'd0, 16'd40000, 16'd65535};
      1: c = '{8'sd90, 7'd90, 16'd40000, 16'd0, 16'd1};
      2: c = '{8'sd0, 7'd0, 16'd1234, 16'd2345, 16'd3456};
      3: c = '{8'sd9, 7'd0, 16'd65535, 16'd0, 16'd40000};
      4: c = '{8'sh80, 7'd127, 16'd32768, 16'd65535, 16'd0};
      5: c = '{8'sh7f, 7'd1, 16'd2500, 16'd3500, 16'd3000};
      default: begin
        c.target_tilt     = 8'(int'($urandom_range(0, 180)) - 90);
        c.band_halfwidth  = 7'($urandom_range(0, 90));
        c.drive_low       = 16'($urandom_range(0, 40000));
        c.drive_high      = 16'($urandom_range(0, 40000));
        c.drive_neutral   = 16'($urandom_range(0, 40000));
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] extreme16();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sh7fff;
    endcase
  endfunction

  // steady runs around a heading in 7 of 16 draws so the average settles, the rest scattered
  function automatic tltz_pkg::in_t random_reading();
    tltz_pkg::in_t rd;
    int  pick;
    pick = $urandom_range(0, 15);
    rd = tltz_pkg::in_t'($urandom);
    if (pick <= 6) begin
      rd.x_accel = clip16(aim_x + int'($urandom_range(0, 3000)) - 1500);
      rd.y_accel = clip16(aim_y + int'($urandom_range(0, 3000)) - 1500);
    end else if (pick == 11) begin
      rd.y_accel = '0;
    end else if (pick == 12) begin
      rd.x_accel = '0;
    end else if (pick == 13) begin
      rd.x_accel = extreme16();
      rd.y_accel = extreme16();
    end else if (pick >= 14) begin
      rd.x_accel = 16'(int'($urandom_range(0, 64)) - 32);
      rd.y_accel = 16'(int'($urandom_range(0, 64)) - 32);
    end
    return rd;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] keep, wdata;
    case (idx)
      tltz_pkg::REG_TARGET_TILT:   keep = 32'h0000_00ff;
      tltz_pkg::REG_ANGLE_TOL:     keep = 32'h0000_007f;
      tltz_pkg::REG_DRIVE_LOW,
      tltz_pkg::REG_DRIVE_HIGH,
      tltz_pkg::REG_DRIVE_NEUTRAL: keep = 32'h0000_ffff;
      default:                     keep = '0;
    endcase
    // junk in the bits above the register width
    wdata = (val & keep) | ($urandom & ~keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tltz_pkg::REG_TARGET_TILT:   shadow_regs.target_tilt    = wdata[7:0];
      tltz_pkg::REG_ANGLE_TOL:     shadow_regs.band_halfwidth = wdata[6:0];
      tltz_pkg::REG_DRIVE_LOW:     shadow_regs.drive_low      = wdata[15:0];
      tltz_pkg::REG_DRIVE_HIGH:    shadow_regs.drive_high     = wdata[15:0];
      tltz_pkg::REG_DRIVE_NEUTRAL: shadow_regs.drive_neutral  = wdata[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input tltz_pkg::in_t rd, input bit known,
                           input tltz_pkg::out_t typed);
    tltz_pkg::out_t predicted;
    if (items_sent % 50 == 0) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
    end
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_window(rd);
    pending_results.push_back(known ? typed : predicted);
    items_sent++;
    calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
  endtask

  initial begin : stimulus
    row_t           row;
    tltz_pkg::cfg_t setting;
    tltz_pkg::in_t  tilt_full;
    shadow_regs = '{8'sd10, 7'd7, 16'd2500, 16'd3500, 16'd3000};
    for (int i = 0; i < WINDOW_LEN; i++) angle_window[i] = '0;
    window_slot = 0;
    window_sum  = 0;
    tilt_full = '{16'sd1, 16'sd0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < N_DIRECTED; k++) begin
      row = directed_row(k);
      send_item(row.item, row.known, row.result);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      setting = phase_setting(p);
      apb_write(tltz_pkg::REG_TARGET_TILT, 32'(setting.target_tilt));
      apb_write(tltz_pkg::REG_ANGLE_TOL, 32'(setting.band_halfwidth));
      apb_write(tltz_pkg::REG_DRIVE_LOW, 32'(setting.drive_low));
      apb_write(tltz_pkg::REG_DRIVE_HIGH, 32'(setting.drive_high));
      apb_write(tltz_pkg::REG_DRIVE_NEUTRAL, 32'(setting.drive_neutral));
      // unmapped index, must be ignored
      apb_write(3'(NUM_REGS + $urandom_range(0, 2)), $urandom);
      // flush the window to zero, then one full tilt: lands on a band edge in some phases
      for (int k = 0; k < WINDOW_LEN; k++) send_item('0, 1'b0, '0);
      send_item(tilt_full, 1'b0, '0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 25 == 0) begin
          aim_x = int'($urandom_range(0, 65535)) - 32768;
          aim_y = int'($urandom_range(0, 65535)) - 32768;
        end
        send_item(random_reading(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("[tilt_level_three_zone_controller_unit] OK");
    end else begin
      $display("[tilt_level_three_zone_controller_unit] ERROR");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin : result_sink
    int  stall_pct;
    int  ticks;
    bit  held;
    stall_pct = 0;
    ticks     = 0;
    held      = 1'b0;
    forever begin
      if (ticks % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      ticks++;
      if (!held && n_results >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    tltz_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.drive_value !== want.drive_value) begin
          $error("drive_value: expected %0d, got %0d", want.drive_value, out_data.drive_value);
          fails++;
        end
        if (out_data.average_angle !== want.average_angle) begin
          $error("average_angle: expected %0d, got %0d",
                 want.average_angle, out_data.average_angle);
          fails++;
        end
        if (out_data.level_zone !== want.level_zone) begin
          $error("level_zone: expected %0d, got %0d", want.level_zone, out_data.level_zone);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[tilt_level_three_zone_controller_unit] ERROR");
      $finish;
    end
  end

endmodule
